// ----- hw/rtl/esc_pkg.sv -----
// Shared constants and codes for the encoder position and speed scaler.
package esc_pkg;

  localparam int unsigned CNT_W      = 32;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned SCALE_W    = 31;
  localparam int unsigned PROD_W     = 62;
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 112;
  localparam int unsigned STEP_W     = 6;

  localparam int unsigned MUL_STEPS     = 31;
  localparam int unsigned DIV_STEPS_POS = 62;
  localparam int unsigned DIV_STEPS_SPD = 31;

  localparam logic [1:0] FN_POS   = 2'd0;
  localparam logic [1:0] FN_SPEED = 2'd1;
  localparam logic [1:0] FN_ZERO  = 2'd2;
  localparam logic [1:0] FN_RESET = 2'd3;

  localparam logic [1:0] CFG_INVERT    = 2'd0;
  localparam logic [1:0] CFG_MUL       = 2'd1;
  localparam logic [1:0] CFG_DIV       = 2'd2;
  localparam logic [1:0] CFG_SPEED_NUM = 2'd3;

  localparam logic [SCALE_W-1:0] MUL_RESET       = 31'd4000;
  localparam logic [SCALE_W-1:0] DIV_RESET       = 31'd3757;
  localparam logic [SCALE_W-1:0] SPEED_NUM_RESET = 31'd7985094;

  localparam logic [PERIOD_W-1:0] PERIOD_INVALID = 16'hffff;

endpackage

// ----- hw/rtl/encoder_position_speed_scaler.sv -----
// Top level of the encoder position and speed scaler: control, state and stream ports.
//
// One input word is taken at a time. A position read passes through the one-bit-per-cycle
// multiplier (31 steps) and then the one-bit-per-cycle divider (62 steps), with setup and
// hand-off states around them. A speed read with a usable period runs 31 divider steps.
// Zero, reset, a speed read with period 0 or 0xffff, a position read with a zero divisor
// register, and any unacknowledged command finish without using the multiplier or divider.
// A finished word sits in the output register while the next input word is accepted.
// Configuration writes are always accepted and must only be issued while the block is idle.
module encoder_position_speed_scaler (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // tdata: acked[0], count_bytes[32:1], period_word[48:33], zero fill
  input  logic [esc_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // tuser: func[1:0]
  input  logic [1:0]                      s_axis_tuser_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // tdata: status[0], position[32:1], scaled_position[64:33], speed[80:65],
  //        scaled_speed[111:81]
  output logic [esc_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [1:0]                      cfg_index_i,
  input  logic [esc_pkg::SCALE_W-1:0]     cfg_data_i
);
  import esc_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_POS  = 3'd1;
  localparam logic [2:0] ST_MULS = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]          state_q;
  logic                invert_q;
  logic [SCALE_W-1:0]  mul_q;
  logic [SCALE_W-1:0]  div_q;
  logic [SCALE_W-1:0]  spd_num_q;
  logic [CNT_W-1:0]    last_count_q;
  logic [CNT_W-1:0]    offset_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                is_speed_q;

  logic                res_status_q;
  logic [CNT_W-1:0]    res_pos_q;
  logic [CNT_W-1:0]    res_spos_q;
  logic [PERIOD_W-1:0] res_speed_q;
  logic [SCALE_W-1:0]  res_sspeed_q;

  logic [OUT_DATA_W-1:0] out_data_q;
  logic                  out_valid_q;

  logic                mul_start_q;
  logic                div_start_q;
  logic [PROD_W-1:0]   div_dividend_q;
  logic [SCALE_W-1:0]  div_divisor_q;
  logic [STEP_W-1:0]   div_steps_q;

  logic                mul_done;
  logic [PROD_W-1:0]   mul_prod;
  logic                div_done;
  logic [PROD_W-1:0]   div_quot;

  logic                in_fire;
  logic [1:0]          in_func;
  logic                in_acked;
  logic [CNT_W-1:0]    in_bytes;
  logic [PERIOD_W-1:0] in_period;
  logic [CNT_W-1:0]    swapped;
  logic [CNT_W-1:0]    spos_mag;

  assign in_func   = s_axis_tuser_i;
  assign in_acked  = s_axis_tdata_i[0];
  assign in_bytes  = s_axis_tdata_i[32:1];
  assign in_period = s_axis_tdata_i[48:33];
  assign swapped   = {in_bytes[15:0], in_bytes[31:16]};
  assign spos_mag  = div_quot[CNT_W-1:0];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  esc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .a_i     (res_pos_q),
    .b_i     (mul_q),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  esc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_dividend_q),
    .divisor_i  (div_divisor_q),
    .steps_i    (div_steps_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q  <= 1'b0;
      mul_q     <= MUL_RESET;
      div_q     <= DIV_RESET;
      spd_num_q <= SPEED_NUM_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_INVERT:    invert_q  <= cfg_data_i[0];
        CFG_MUL:       mul_q     <= cfg_data_i;
        CFG_DIV:       div_q     <= cfg_data_i;
        CFG_SPEED_NUM: spd_num_q <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      last_count_q <= '0;
      offset_q     <= '0;
      mul_start_q  <= 1'b0;
      div_start_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
      if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            state_q <= ST_FIN;
            if (in_func == FN_ZERO) begin
              offset_q <= ~last_count_q + 32'd1;
            end else if (!in_acked) begin
              state_q <= ST_FIN;
            end else if (in_func == FN_POS) begin
              last_count_q <= invert_q ? (~swapped + 32'd1) : swapped;
              state_q      <= ST_POS;
            end else if (in_func == FN_SPEED) begin
              if (in_period != '0 && in_period != PERIOD_INVALID) begin
                div_start_q <= 1'b1;
                state_q     <= ST_DIV;
              end
            end else begin
              offset_q     <= '0;
              last_count_q <= '0;
            end
          end
        end
        ST_POS: begin
          state_q <= ST_MULS;
        end
        ST_MULS: begin
          if (div_q == '0) begin
            state_q <= ST_FIN;
          end else begin
            mul_start_q <= 1'b1;
            state_q     <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            div_start_q <= 1'b1;
            state_q     <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          res_status_q   <= (in_func != FN_ZERO) && !in_acked;
          res_pos_q      <= '0;
          res_spos_q     <= '0;
          res_speed_q    <= '0;
          res_sspeed_q   <= '0;
          is_speed_q     <= (in_func == FN_SPEED);
          cnt_q          <= invert_q ? (~swapped + 32'd1) : swapped;
          div_dividend_q <= {spd_num_q, {DIV_STEPS_SPD{1'b0}}};
          div_divisor_q  <= {{(SCALE_W-PERIOD_W){1'b0}}, in_period};
          div_steps_q    <= STEP_W'(DIV_STEPS_SPD);
          if ((in_func == FN_SPEED) && in_acked) begin
            res_speed_q <= in_period;
          end
        end
      end
      ST_POS: begin
        res_pos_q <= cnt_q - offset_q;
      end
      ST_MUL: begin
        if (mul_done) begin
          div_dividend_q <= mul_prod;
          div_divisor_q  <= div_q;
          div_steps_q    <= STEP_W'(DIV_STEPS_POS);
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (is_speed_q) begin
            res_sspeed_q <= div_quot[SCALE_W-1:0];
          end else begin
            res_spos_q <= res_pos_q[CNT_W-1] ? (~spos_mag + 32'd1) : spos_mag;
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_data_q <= {res_sspeed_q, res_speed_q, res_spos_q, res_pos_q, res_status_q};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tvalid_o = out_valid_q;

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start_q |-> (div_divisor_q != '0))
    else $error("divider started with a zero divisor");

  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_done && div_done))
    else $error("multiplier and divider finished together");

  a_nak_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !in_acked && (in_func != FN_ZERO)) |=> (res_status_q && (state_q == ST_FIN)))
    else $error("unacknowledged command did not report an error");

  a_mul_from_muls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start_q |-> ($past(state_q) == ST_MULS) && (div_q != '0))
    else $error("multiplier started outside the position path");

endmodule

// ----- hw/rtl/esc_mul.sv -----
// Bit-serial shift-add multiplier: magnitude of a signed count times an unsigned scale.
module esc_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [esc_pkg::CNT_W-1:0]     a_i,
  input  logic [esc_pkg::SCALE_W-1:0]   b_i,
  output logic                          done_o,
  output logic [esc_pkg::PROD_W-1:0]    prod_o
);
  import esc_pkg::*;

  logic [CNT_W-1:0]   a_q;
  logic [CNT_W-1:0]   hi_q;
  logic [SCALE_W-1:0] lo_q;
  logic [4:0]         cnt_q;
  logic               run_q;
  logic               done_q;
  logic [CNT_W:0]     sum;

  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : {(CNT_W+1){1'b0}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 5'(MUL_STEPS - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i[CNT_W-1] ? (~a_i + 32'd1) : a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (run_q) begin
      hi_q <= sum[CNT_W:1];
      lo_q <= {sum[0], lo_q[SCALE_W-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q[PROD_W-SCALE_W-1:0], lo_q};

endmodule

// ----- hw/rtl/esc_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
module esc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [esc_pkg::PROD_W-1:0]    dividend_i,
  input  logic [esc_pkg::SCALE_W-1:0]   divisor_i,
  input  logic [esc_pkg::STEP_W-1:0]    steps_i,
  output logic                          done_o,
  output logic [esc_pkg::PROD_W-1:0]    quot_o
);
  import esc_pkg::*;

  logic [PROD_W-1:0]  dq_q;
  logic [SCALE_W-1:0] rem_q;
  logic [SCALE_W-1:0] dvs_q;
  logic [STEP_W-1:0]  cnt_q;
  logic               run_q;
  logic               done_q;
  logic [SCALE_W:0]   shifted;
  logic [SCALE_W+1:0] diff;

  assign shifted = {rem_q, dq_q[PROD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= steps_i - 6'd1;
      end else if (run_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      if (!diff[SCALE_W+1]) begin
        rem_q <= diff[SCALE_W-1:0];
        dq_q  <= {dq_q[PROD_W-2:0], 1'b1};
      end else begin
        rem_q <= shifted[SCALE_W-1:0];
        dq_q  <= {dq_q[PROD_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule
